@@ rtl/core/adc_ladder_keypad_decoder_defines.svh @@
// assertion macros used by the keypad decoder back end
`ifndef ADC_LADDER_KEYPAD_DECODER_DEFINES_SVH
`define ADC_LADDER_KEYPAD_DECODER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ALKD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad decoder check failed");

// next-cycle implication
`define ALKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad decoder check failed");

`endif

@@ rtl/core/alkd_pkg.sv @@
// types and constants of the keypad decoder
package alkd_pkg;

    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned LEVEL_W     = 12;
    localparam int unsigned TRY_W       = 6;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned NUM_SWITCH  = 6;

    localparam logic OP_TRIGGER = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    // classification codes: 0 none, 1..6 switch, 7 undetermined
    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_UNDET = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_BANK_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_DELTA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LEFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_RIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_UP       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DOWN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HOME     = 3'd7;

    localparam logic [LEVEL_W-1:0] RST_NONE_THRESHOLD = 12'd3800;
    localparam logic [LEVEL_W-1:0] RST_WINDOW_DELTA   = 12'd100;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_LEFT     = 12'd2458;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_RIGHT    = 12'd3016;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_UP       = 12'd3376;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_DOWN     = 12'd1663;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_HOME     = 12'd745;

    typedef enum logic [2:0] {
        EV_WANT     = 3'd0,
        EV_REFUSED  = 3'd1,
        EV_GAVE_UP  = 3'd2,
        EV_SAME     = 3'd3,
        EV_RELEASED = 3'd4,
        EV_PRESSED  = 3'd5
    } event_kind_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] none_threshold;
        logic [LEVEL_W-1:0] window_delta;
        logic [LEVEL_W-1:0] level_left;
        logic [LEVEL_W-1:0] level_right;
        logic [LEVEL_W-1:0] level_up;
        logic [LEVEL_W-1:0] level_down;
        logic [LEVEL_W-1:0] level_home;
    } window_cfg_t;

    typedef struct packed {
        logic       opcode;
        logic       bank;
        logic [2:0] cls;
    } q_entry_t;

    typedef struct packed {
        logic        bank_out;
        event_kind_t event_kind;
        logic [2:0]  switch_num;
        logic        last;
    } result_t;

endpackage

@@ rtl/core/alkd_if.sv @@
// valid/ready channel interfaces of the keypad decoder
interface alkd_in_if import alkd_pkg::*;;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic                bank;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output opcode, output bank, output sample, input ready);
    modport sink   (input valid, input opcode, input bank, input sample, output ready);
endinterface

interface alkd_out_if;
    logic       valid;
    logic       ready;
    logic       bank_out;
    logic [2:0] event_kind;
    logic [2:0] switch_num;
    logic       last;

    modport source (output valid, output bank_out, output event_kind, output switch_num,
                    output last, input ready);
    modport sink   (input valid, input bank_out, input event_kind, input switch_num,
                    input last, output ready);
endinterface

@@ rtl/core/alkd_front.sv @@
// front end: accepts items and classifies adc samples against the level windows
module alkd_front import alkd_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    alkd_in_if.sink     in_ch,
    input  window_cfg_t win,
    input  logic        q_full,
    output logic        push,
    output q_entry_t    entry
);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= SAMPLE_W) ?
        {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    logic [SAMPLE_W-1:0] s;
    logic [LEVEL_W-1:0]  lv [NUM_SWITCH];
    logic [LEVEL_W-1:0]  lo [NUM_SWITCH];
    logic [LEVEL_W:0]    hi [NUM_SWITCH];
    logic [2:0]          cls;

    assign s = in_ch.sample & SAMPLE_MASK;

    always_comb
    begin
        lv[0] = win.level_left;
        lv[1] = win.level_right;
        lv[2] = win.level_up;
        lv[3] = win.level_down;
        lv[4] = win.level_home;
        lv[5] = '0;
        for (int k = 0; k < NUM_SWITCH; k++)
        begin
            lo[k] = (lv[k] > win.window_delta) ? lv[k] - win.window_delta : '0;
            hi[k] = {1'b0, lv[k]} + {1'b0, win.window_delta};
        end
    end

    // first matching window wins, so scan from the last one down
    always_comb
    begin
        cls = CLS_UNDET;
        if (s > win.none_threshold)
        begin
            cls = CLS_NONE;
        end
        else
        begin
            for (int k = NUM_SWITCH - 1; k >= 0; k--)
            begin
                if (s >= lo[k] && {1'b0, s} <= hi[k])
                begin
                    cls = 3'(k + 1);
                end
            end
        end
    end

    assign in_ch.ready  = !q_full;
    assign push         = in_ch.valid && !q_full;
    assign entry.opcode = in_ch.opcode;
    assign entry.bank   = in_ch.bank;
    assign entry.cls    = cls;

endmodule

@@ rtl/core/alkd_queue.sv @@
// short fifo between the classifier and the bank sequencer
module alkd_queue import alkd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t wr_entry,
    input  logic     pop,
    output q_entry_t rd_entry,
    output logic     full,
    output logic     empty
);

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (QPTR_W + 1)'(1);
            2'b01:   count_next = count_reg - (QPTR_W + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ rtl/core/alkd_back.sv @@
// back end: per-bank debounce state, try counting and event generation
`include "adc_ladder_keypad_decoder_defines.svh"

module alkd_back import alkd_pkg::*; #(
    parameter int unsigned AGREE_COUNT = 8,
    parameter int unsigned TRY_LIMIT   = 40,
    parameter int unsigned NUM_BANKS   = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  bank_enable,
    input  logic        q_empty,
    input  q_entry_t    head,
    output logic        pop,
    alkd_out_if.source  out_ch
);

    // the bank field is one bit wide, so at most two banks are reachable
    localparam int unsigned NB    = (NUM_BANKS < 2) ? NUM_BANKS : 2;
    localparam int unsigned CNT_W = $clog2(AGREE_COUNT + 1);
    localparam logic [CNT_W-1:0] AGREE_N = CNT_W'(AGREE_COUNT);

    // the ring is tracked as the length of the current run of equal readings
    logic             active_reg  [NB];
    logic [TRY_W-1:0] tries_reg   [NB];
    logic [CNT_W-1:0] run_cnt_reg [NB];
    logic [2:0]       run_cls_reg [NB];
    logic [2:0]       pressed_reg [NB];

    logic             active_next;
    logic [TRY_W-1:0] tries_next;
    logic [CNT_W-1:0] run_cnt_next;
    logic [2:0]       run_cls_next;
    logic [2:0]       pressed_next;

    logic             bidx;
    logic             bank_ok;
    logic             agree;
    logic             two;
    result_t          r1;
    result_t          r2;

    logic             out_valid_reg;
    result_t          out_reg;
    logic             pend_reg;
    result_t          second_reg;
    logic             load;

    assign bidx    = (NB > 1) ? head.bank : 1'b0;
    assign bank_ok = (NUM_BANKS > 1) || (head.bank == 1'b0);
    assign load    = !out_valid_reg || out_ch.ready;
    assign pop     = load && !pend_reg && !q_empty;

    always_comb
    begin
        active_next  = active_reg[bidx];
        tries_next   = tries_reg[bidx];
        run_cnt_next = run_cnt_reg[bidx];
        run_cls_next = run_cls_reg[bidx];
        pressed_next = pressed_reg[bidx];
        agree        = 1'b0;
        two          = 1'b0;
        r1 = '{bank_out: head.bank, event_kind: EV_REFUSED, switch_num: 3'd0, last: 1'b1};
        r2 = '{bank_out: head.bank, event_kind: EV_PRESSED, switch_num: head.cls, last: 1'b1};
        if (!bank_ok)
        begin
            r1.event_kind = EV_REFUSED;
        end
        else if (head.opcode == OP_TRIGGER)
        begin
            if (bank_enable[head.bank] && !active_reg[bidx])
            begin
                active_next  = 1'b1;
                run_cnt_next = '0;
                if (TRY_LIMIT <= 1)
                begin
                    tries_next    = '0;
                    active_next   = 1'b0;
                    r1.event_kind = EV_GAVE_UP;
                end
                else
                begin
                    tries_next    = TRY_W'(TRY_LIMIT - 1);
                    r1.event_kind = EV_WANT;
                end
            end
        end
        else if (active_reg[bidx])
        begin
            if (head.cls != CLS_UNDET)
            begin
                run_cls_next = head.cls;
                if (run_cnt_reg[bidx] != '0 && run_cls_reg[bidx] == head.cls)
                begin
                    run_cnt_next = (run_cnt_reg[bidx] >= AGREE_N) ?
                        run_cnt_reg[bidx] : run_cnt_reg[bidx] + CNT_W'(1);
                end
                else
                begin
                    run_cnt_next = CNT_W'(1);
                end
            end
            agree = (run_cnt_next >= AGREE_N);
            if (!agree)
            begin
                if (tries_reg[bidx] <= TRY_W'(1))
                begin
                    tries_next    = '0;
                    active_next   = 1'b0;
                    r1.event_kind = EV_GAVE_UP;
                end
                else
                begin
                    tries_next    = tries_reg[bidx] - TRY_W'(1);
                    r1.event_kind = EV_WANT;
                end
            end
            else
            begin
                active_next  = 1'b0;
                pressed_next = head.cls;
                if (pressed_reg[bidx] == head.cls)
                begin
                    r1.event_kind = EV_SAME;
                end
                else if (pressed_reg[bidx] != CLS_NONE)
                begin
                    // release goes out first, press follows when a switch is held
                    r1.event_kind = EV_RELEASED;
                    r1.switch_num = pressed_reg[bidx];
                    r1.last       = (head.cls == CLS_NONE);
                    two           = (head.cls != CLS_NONE);
                end
                else
                begin
                    r1.event_kind = EV_PRESSED;
                    r1.switch_num = head.cls;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NB; b++)
            begin
                active_reg[b]  <= 1'b0;
                tries_reg[b]   <= '0;
                run_cnt_reg[b] <= '0;
                run_cls_reg[b] <= CLS_NONE;
                pressed_reg[b] <= CLS_NONE;
            end
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (pop && bank_ok)
            begin
                active_reg[bidx]  <= active_next;
                tries_reg[bidx]   <= tries_next;
                run_cnt_reg[bidx] <= run_cnt_next;
                run_cls_reg[bidx] <= run_cls_next;
                pressed_reg[bidx] <= pressed_next;
            end
            if (load)
            begin
                if (pend_reg)
                begin
                    out_valid_reg <= 1'b1;
                    pend_reg      <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= pop;
                    pend_reg      <= pop && two;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                out_reg <= second_reg;
            end
            else if (pop)
            begin
                out_reg    <= r1;
                second_reg <= r2;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.bank_out   = out_reg.bank_out;
    assign out_ch.event_kind = out_reg.event_kind;
    assign out_ch.switch_num = out_reg.switch_num;
    assign out_ch.last       = out_reg.last;

    `ALKD_ASSERT_IMPL(a_pend_behind_first, pend_reg, out_valid_reg && !out_reg.last)
    `ALKD_ASSERT_NEXT(a_second_follows, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid)
    `ALKD_ASSERT_IMPL(a_pop_nonempty, pop, !q_empty)
    `ALKD_ASSERT_IMPL(a_active_has_tries, active_reg[0], tries_reg[0] != '0)

endmodule

@@ rtl/core/adc_ladder_keypad_decoder.sv @@
// top level of the resistor-ladder keypad decoder
// usage:
//   in_ch carries one item per transfer: opcode 0 triggers a read of a bank,
//   opcode 1 delivers an adc sample for that bank. out_ch carries results:
//   one per item, two when a settled read both releases and presses a switch
//   (release first, last set on the final one). the user must write registers
//   through cfg_we / cfg_index / cfg_wdata while idle; the block never checks.
// timing:
//   an item transferred on in_ch is registered in the queue; once popped,
//   its first result is loaded into the output register, from which it can
//   transfer. one item per cycle is sustained while out_ch is ready, limited
//   by the single per-bank update in the sequencer; an item with two results
//   holds back the queue until its second result is loaded into the output.
// stalls:
//   the four-entry queue keeps in_ch ready while out_ch is stalled, and
//   in_ch ready drops only once the queue is full.
// reset:
//   all banks idle with no switch pressed, the queue empty, registers at
//   their defaults (all banks disabled).
module adc_ladder_keypad_decoder import alkd_pkg::*; #(
    parameter int unsigned AGREE_COUNT = 8,
    parameter int unsigned TRY_LIMIT   = 40,
    parameter int unsigned NUM_BANKS   = 2,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    alkd_in_if.sink               in_ch,
    alkd_out_if.source            out_ch
);

    logic [1:0]  bank_enable_reg;
    window_cfg_t win_reg;

    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    q_entry_t    wr_entry;
    q_entry_t    head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_enable_reg        <= 2'b00;
            win_reg.none_threshold <= RST_NONE_THRESHOLD;
            win_reg.window_delta   <= RST_WINDOW_DELTA;
            win_reg.level_left     <= RST_LEVEL_LEFT;
            win_reg.level_right    <= RST_LEVEL_RIGHT;
            win_reg.level_up       <= RST_LEVEL_UP;
            win_reg.level_down     <= RST_LEVEL_DOWN;
            win_reg.level_home     <= RST_LEVEL_HOME;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BANK_ENABLE:    bank_enable_reg        <= cfg_wdata[1:0];
                REG_NONE_THRESHOLD: win_reg.none_threshold <= cfg_wdata;
                REG_WINDOW_DELTA:   win_reg.window_delta   <= cfg_wdata;
                REG_LEVEL_LEFT:     win_reg.level_left     <= cfg_wdata;
                REG_LEVEL_RIGHT:    win_reg.level_right    <= cfg_wdata;
                REG_LEVEL_UP:       win_reg.level_up       <= cfg_wdata;
                REG_LEVEL_DOWN:     win_reg.level_down     <= cfg_wdata;
                REG_LEVEL_HOME:     win_reg.level_home     <= cfg_wdata;
                default:            bank_enable_reg        <= bank_enable_reg;
            endcase
        end
    end

    alkd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .in_ch  (in_ch),
        .win    (win_reg),
        .q_full (q_full),
        .push   (push),
        .entry  (wr_entry)
    );

    alkd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    alkd_back #(
        .AGREE_COUNT (AGREE_COUNT),
        .TRY_LIMIT   (TRY_LIMIT),
        .NUM_BANKS   (NUM_BANKS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .bank_enable (bank_enable_reg),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

@@ dv/tb.sv @@
// testbench for the keypad decoder: predicted events checked against each out_ch transfer
`timescale 1ns / 1ps

module tb;
    import alkd_pkg::*;

    localparam int          AGREE_N    = 8;
    localparam int          TRY_MAX    = 40;
    localparam int          HOLD_LEN   = 60;
    localparam int          PHASE_LEN  = 130;
    localparam logic [3:0]  RING_EMPTY = 4'd15;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    alkd_in_if  in_ch ();
    alkd_out_if out_ch ();

    adc_ladder_keypad_decoder #(
        .AGREE_COUNT (AGREE_N),
        .TRY_LIMIT   (TRY_MAX),
        .NUM_BANKS   (2),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // register copies and per-bank debounce state
    logic [1:0]            cfg_banks;
    window_cfg_t           cfg_windows;
    logic [3:0]            ring [2][AGREE_N];
    logic [2:0]            ring_pos [2];
    logic [TRY_W-1:0]      tries [2];
    logic                  busy [2];
    logic [NUM_SWITCH-1:0] held [2];

    result_t expected_events [$];
    int      mismatches = 0;
    bit      steady_flow = 1'b0;
    bit      hold_output = 1'b0;

    function automatic logic [2:0] classify_level(input logic [SAMPLE_W-1:0] s);
        logic [LEVEL_W-1:0] lv [NUM_SWITCH];
        logic [LEVEL_W:0]   lo;
        logic [LEVEL_W:0]   hi;
        logic [2:0]         cls;
        if (s > cfg_windows.none_threshold)
            return CLS_NONE;
        lv[0] = cfg_windows.level_left;
        lv[1] = cfg_windows.level_right;
        lv[2] = cfg_windows.level_up;
        lv[3] = cfg_windows.level_down;
        lv[4] = cfg_windows.level_home;
        lv[5] = '0;
        cls = CLS_UNDET;
        for (int k = 0; k < NUM_SWITCH; k++)
        begin
            lo = (lv[k] > cfg_windows.window_delta) ?
                 {1'b0, lv[k]} - cfg_windows.window_delta : '0;
            hi = {1'b0, lv[k]} + cfg_windows.window_delta;
            // first matching window wins
            if (cls == CLS_UNDET && s >= lo && s <= hi)
                cls = 3'(k + 1);
        end
        return cls;
    endfunction

    function automatic event_kind_t spend_try(input logic b);
        if (tries[b] <= 1)
        begin
            tries[b] = '0;
            busy[b]  = 1'b0;
            return EV_GAVE_UP;
        end
        tries[b] = tries[b] - 1'b1;
        return EV_WANT;
    endfunction

    function automatic result_t make_event(input logic b, input event_kind_t kind,
                                           input logic [2:0] sw);
        result_t r;
        r.bank_out   = b;
        r.event_kind = kind;
        r.switch_num = sw;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic decode_keypad_item(input logic op, input logic b,
                                      input logic [SAMPLE_W-1:0] s);
        result_t               evs [$];
        logic [2:0]            cls;
        logic [3:0]            first;
        logic                  agree;
        logic [NUM_SWITCH-1:0] newm;
        logic [NUM_SWITCH-1:0] rel;
        logic [NUM_SWITCH-1:0] prs;
        if (op == OP_TRIGGER)
        begin
            if (!cfg_banks[b] || busy[b])
                evs.push_back(make_event(b, EV_REFUSED, '0));
            else
            begin
                busy[b]     = 1'b1;
                ring_pos[b] = '0;
                tries[b]    = TRY_W'(TRY_MAX);
                for (int i = 0; i < AGREE_N; i++)
                    ring[b][i] = RING_EMPTY;
                evs.push_back(make_event(b, spend_try(b), '0));
            end
        end
        else if (!busy[b])
            evs.push_back(make_event(b, EV_REFUSED, '0));
        else
        begin
            cls = classify_level(s);
            // undetermined readings never enter the ring
            if (cls != CLS_UNDET)
            begin
                ring[b][ring_pos[b]] = {1'b0, cls};
                ring_pos[b] = (ring_pos[b] == AGREE_N - 1) ? '0 : ring_pos[b] + 1'b1;
            end
            first = ring[b][0];
            agree = (first != RING_EMPTY);
            for (int i = 1; i < AGREE_N; i++)
                if (ring[b][i] != first)
                    agree = 1'b0;
            if (!agree)
                evs.push_back(make_event(b, spend_try(b), '0));
            else
            begin
                busy[b] = 1'b0;
                newm = (first == CLS_NONE) ? '0 : 6'd1 << (first - 4'd1);
                rel  = held[b] & ~newm;
                prs  = newm & ~held[b];
                for (int i = 0; i < NUM_SWITCH; i++)
                    if (rel[i])
                        evs.push_back(make_event(b, EV_RELEASED, 3'(i + 1)));
                for (int i = 0; i < NUM_SWITCH; i++)
                    if (prs[i] && evs.size() < 2)
                        evs.push_back(make_event(b, EV_PRESSED, 3'(i + 1)));
                held[b] = newm;
                if (evs.size() == 0)
                    evs.push_back(make_event(b, EV_SAME, '0));
            end
        end
        evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i])
            expected_events.push_back(evs[i]);
    endtask

    // a sample somewhere in the window of the given class, given the current levels
    function automatic logic [SAMPLE_W-1:0] sample_near(input int cls);
        int lv;
        int lo;
        int hi;
        case (cls)
            1: lv = cfg_windows.level_left;
            2: lv = cfg_windows.level_right;
            3: lv = cfg_windows.level_up;
            4: lv = cfg_windows.level_down;
            5: lv = cfg_windows.level_home;
            default: lv = 0;
        endcase
        if (cls == CLS_NONE)
        begin
            if (cfg_windows.none_threshold < 4095)
                return SAMPLE_W'($urandom_range(4095, cfg_windows.none_threshold + 1));
            return SAMPLE_W'($urandom_range(4095, 0));
        end
        lo = lv - int'(cfg_windows.window_delta);
        hi = lv + int'(cfg_windows.window_delta);
        if (lo < 0)
            lo = 0;
        if (hi > 4095)
            hi = 4095;
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    task automatic send_keypad_item(input logic op, input logic b,
                                    input logic [SAMPLE_W-1:0] s);
        @(negedge clk);
        if (!steady_flow && $urandom_range(99, 0) < 8)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.opcode = op;
        in_ch.bank   = b;
        in_ch.sample = s;
        do
            @(posedge clk);
        while (!in_ch.ready);
        decode_keypad_item(op, b, s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_BANK_ENABLE:    cfg_banks                  = val[1:0];
            REG_NONE_THRESHOLD: cfg_windows.none_threshold = val;
            REG_WINDOW_DELTA:   cfg_windows.window_delta   = val;
            REG_LEVEL_LEFT:     cfg_windows.level_left     = val;
            REG_LEVEL_RIGHT:    cfg_windows.level_right    = val;
            REG_LEVEL_UP:       cfg_windows.level_up       = val;
            REG_LEVEL_DOWN:     cfg_windows.level_down     = val;
            REG_LEVEL_HOME:     cfg_windows.level_home     = val;
            default: ;
        endcase
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        // every item yields a result, a short pause covers the pipeline
        repeat (6) @(posedge clk);
    endtask

    task automatic test_refusals();
        send_keypad_item(OP_TRIGGER, 1'b0, '0);
        send_keypad_item(OP_TRIGGER, 1'b1, '1);
        send_keypad_item(OP_SAMPLE, 1'b0, '0);
        send_keypad_item(OP_SAMPLE, 1'b1, '1);
        wait_for_results();
    endtask

    task automatic test_settled_reads();
        write_reg(REG_BANK_ENABLE, 12'd3);
        send_keypad_item(OP_TRIGGER, 1'b0, '0);
        send_keypad_item(OP_TRIGGER, 1'b0, '0);
        send_keypad_item(OP_TRIGGER, 1'b1, '0);
        // an undetermined reading in the middle does not break agreement
        repeat (4) send_keypad_item(OP_SAMPLE, 1'b0, RST_LEVEL_LEFT);
        send_keypad_item(OP_SAMPLE, 1'b0, 12'd2000);
        repeat (4) send_keypad_item(OP_SAMPLE, 1'b0, RST_LEVEL_LEFT);
        // different switch: release and press from one sample
        send_keypad_item(OP_TRIGGER, 1'b0, '0);
        repeat (8) send_keypad_item(OP_SAMPLE, 1'b0, RST_LEVEL_RIGHT);
        wait_for_results();
    endtask

    task automatic test_input_backpressure();
        hold_output = 1'b1;
        repeat (20)
            send_keypad_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                             SAMPLE_W'($urandom));
        wait_for_results();
    endtask

    task automatic apply_phase_config(input int phase);
        logic [CFG_DATA_W-1:0] v [8];
        for (int i = 0; i < 8; i++)
            v[i] = CFG_DATA_W'($urandom_range(4095, 0));
        v[REG_BANK_ENABLE] = ($urandom_range(3, 0) == 0) ?
                             CFG_DATA_W'($urandom_range(3, 0)) : 12'd3;
        case (phase)
            0:
            begin
                v[REG_BANK_ENABLE]    = 12'd3;
                v[REG_NONE_THRESHOLD] = RST_NONE_THRESHOLD;
                v[REG_WINDOW_DELTA]   = RST_WINDOW_DELTA;
                v[REG_LEVEL_LEFT]     = RST_LEVEL_LEFT;
                v[REG_LEVEL_RIGHT]    = RST_LEVEL_RIGHT;
                v[REG_LEVEL_UP]       = RST_LEVEL_UP;
                v[REG_LEVEL_DOWN]     = RST_LEVEL_DOWN;
                v[REG_LEVEL_HOME]     = RST_LEVEL_HOME;
            end
            1:
            begin
                v[REG_BANK_ENABLE]    = 12'd3;
                v[REG_NONE_THRESHOLD] = 12'd4095;
                v[REG_WINDOW_DELTA]   = 12'd0;
            end
            2:
            begin
                v[REG_BANK_ENABLE]    = 12'd1;
                v[REG_NONE_THRESHOLD] = 12'd0;
                v[REG_WINDOW_DELTA]   = 12'd4095;
            end
            3:
            begin
                v[REG_BANK_ENABLE]    = 12'd2;
                v[REG_WINDOW_DELTA]   = 12'd200;
                v[REG_LEVEL_LEFT]     = 12'd4095;
                v[REG_LEVEL_RIGHT]    = 12'd0;
                v[REG_LEVEL_UP]       = 12'd4095;
                v[REG_LEVEL_DOWN]     = 12'd0;
                v[REG_LEVEL_HOME]     = 12'd4095;
            end
            default:
                v[REG_WINDOW_DELTA] = CFG_DATA_W'($urandom_range(400, 0));
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(CFG_IDX_W'(i), v[i]);
    endtask

    task automatic test_random_reads();
        int                  sent;
        int                  budget;
        int                  target;
        bit                  noisy;
        logic                b;
        logic [SAMPLE_W-1:0] s;
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_for_results();
            apply_phase_config(phase);
            steady_flow = (phase == 1);
            sent = 0;
            while (sent < PHASE_LEN)
            begin
                b = 1'($urandom_range(1, 0));
                if ($urandom_range(99, 0) < 10)
                begin
                    send_keypad_item(1'($urandom_range(1, 0)), b, SAMPLE_W'($urandom));
                    sent++;
                end
                else
                begin
                    target = $urandom_range(6, 0);
                    noisy  = ($urandom_range(99, 0) < 20);
                    // some reads are cut short and left hanging
                    budget = ($urandom_range(99, 0) < 15) ? $urandom_range(6, 1) : 2 * TRY_MAX;
                    send_keypad_item(OP_TRIGGER, b, SAMPLE_W'($urandom));
                    sent++;
                    while (busy[b] && budget > 0)
                    begin
                        if (noisy || $urandom_range(99, 0) < 8)
                            s = SAMPLE_W'($urandom);
                        else if ($urandom_range(99, 0) < 5)
                            s = sample_near($urandom_range(6, 0));
                        else
                            s = sample_near(target);
                        send_keypad_item(OP_SAMPLE, b, s);
                        sent++;
                        budget--;
                    end
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_ch.ready = 1'b0;
                repeat (HOLD_LEN - 1) @(negedge clk);
                hold_output = 1'b0;
            end
            else
                out_ch.ready = steady_flow || ($urandom_range(99, 0) >= 16);
        end
    end

    function automatic void check_field(input string name, input logic [2:0] exp,
                                        input logic [2:0] act);
        if (act !== exp)
        begin
            $error("%s: expected %0d, actual %0d", name, exp, act);
            mismatches++;
        end
    endfunction

    // compare each out_ch transfer with the oldest predicted event
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected result: bank %0d kind %0d switch %0d last %0d",
                           out_ch.bank_out, out_ch.event_kind, out_ch.switch_num, out_ch.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("bank_out", want.bank_out, out_ch.bank_out);
                    check_field("event_kind", want.event_kind, out_ch.event_kind);
                    check_field("switch_num", want.switch_num, out_ch.switch_num);
                    check_field("last", want.last, out_ch.last);
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("** adc_ladder_keypad_decoder: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.opcode = OP_TRIGGER;
        in_ch.bank   = 1'b0;
        in_ch.sample = '0;
        cfg_banks                  = '0;
        cfg_windows.none_threshold = RST_NONE_THRESHOLD;
        cfg_windows.window_delta   = RST_WINDOW_DELTA;
        cfg_windows.level_left     = RST_LEVEL_LEFT;
        cfg_windows.level_right    = RST_LEVEL_RIGHT;
        cfg_windows.level_up       = RST_LEVEL_UP;
        cfg_windows.level_down     = RST_LEVEL_DOWN;
        cfg_windows.level_home     = RST_LEVEL_HOME;
        for (int b = 0; b < 2; b++)
        begin
            for (int i = 0; i < AGREE_N; i++)
                ring[b][i] = RING_EMPTY;
            ring_pos[b] = '0;
            tries[b]    = '0;
            busy[b]     = 1'b0;
            held[b]     = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_refusals();
        test_settled_reads();
        test_input_backpressure();
        test_random_reads();

        wait_for_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("** adc_ladder_keypad_decoder: PASSED **");
        else
            $display("** adc_ladder_keypad_decoder: FAILED **");
        $finish;
    end

endmodule

@@ adc_ladder_keypad_decoder.f @@
+incdir+rtl/core
rtl/core/alkd_pkg.sv
rtl/core/alkd_if.sv
rtl/core/alkd_front.sv
rtl/core/alkd_queue.sv
rtl/core/alkd_back.sv
rtl/core/adc_ladder_keypad_decoder.sv
dv/tb.sv
